// File: design/region_sum_sorted_report_unit_assert.svh
// assertion macros for the region sum report unit
// used by rssr_div and region_sum_sorted_report_unit
`ifndef REGION_SUM_SORTED_REPORT_UNIT_ASSERT_SVH
`define REGION_SUM_SORTED_REPORT_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define RSSR_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define RSSR_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: design/rssr_pkg.sv
// types and constants for the region sum report unit
// no dependencies
`timescale 1ns / 1ps

package rssr_pkg;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_ASC  = 2'd1;
    localparam logic [1:0] CMD_DESC = 2'd2;

    localparam int TOTAL_W = 32;
    localparam int COUNT_W = 16;
    localparam int AVG_W   = 16;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  region;
        logic [15:0] rain_amount;
        logic [15:0] past_rain_amount;
    } cmd_item_t;

    typedef struct packed {
        logic [4:0]  region_id;
        logic [31:0] total_rain;
        logic [15:0] average_rain;
        logic [15:0] average_difference;
        logic        no_data;
        logic        last;
    } report_item_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

endpackage

// File: design/rssr_if.sv
// valid/ready channel carrying one payload item
// no dependencies
`timescale 1ns / 1ps

interface rssr_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/rssr_div.sv
// restoring divider, one quotient bit per cycle, result clamped to 16 bits
// depends on rssr_pkg and the assertion header
`timescale 1ns / 1ps
`include "region_sum_sorted_report_unit_assert.svh"

module rssr_div
    import rssr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [31:0] quot_reg, quot_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] shifted;
    logic [16:0] diff;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[15:0], quot_reg[31]};
        diff      = shifted - {1'b0, dsr_reg};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[16])
            begin
                rem_next  = diff;
                quot_next = {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                quot_next = {quot_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = (quot_reg[31:16] != 16'd0) ? 16'hFFFF : quot_reg[15:0];

    `RSSR_ASSERT_NEXT(a_div_start_busy, clk, rst_n, req.start, busy_reg, "divider did not start")
    `RSSR_ASSERT_IMP(a_div_done_idle, clk, rst_n, done_reg, !busy_reg, "done while busy")
    `RSSR_ASSERT_IMP(a_div_cnt, clk, rst_n, busy_reg, cnt_reg != 6'd0, "busy with zero count")

endmodule

// File: design/region_sum_sorted_report_unit.sv
// add: accepted while idle; ready stays high after it
// report: insertion sort one compare a cycle, then one line per region: for a line with records
// two 32-step divisions on the shared divider, none if empty
// input stays blocked until the last report line leaves the output register
// reset clears all totals and counts at once; sort order is scratch
// depends on rssr_pkg, rssr_if, rssr_div and the assertion header
`timescale 1ns / 1ps
`include "region_sum_sorted_report_unit_assert.svh"

module region_sum_sorted_report_unit
    import rssr_pkg::*;
#(
    parameter int REGIONS = 6
)
(
    input logic clk,
    input logic rst_n,
    rssr_if.sink   cmd,
    rssr_if.source report
);

    localparam int IW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int CW = $clog2(REGIONS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INIT  = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_DIVA  = 7'b0001000,
        S_DIVP  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_WAIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [TOTAL_W-1:0] cur_reg [REGIONS];
    logic [TOTAL_W-1:0] past_reg [REGIONS];
    logic [COUNT_W-1:0] cnt_reg [REGIONS];
    logic [IW-1:0]      ord_reg [REGIONS];

    logic          desc_reg;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [IW-1:0] key_reg, key_next;
    logic [CW-1:0] k_reg, k_next;
    logic [AVG_W-1:0] avg_reg;
    report_item_t  out_reg;
    logic          out_valid_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    rssr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [IW-1:0] prev_idx, cur_idx;
    logic [TOTAL_W-1:0] tk, tp;
    logic key_first;
    logic [TOTAL_W:0] sum_c, sum_p;
    logic [3:0] radd;
    logic [IW-1:0] rx;
    logic accept;
    logic [AVG_W-1:0] q;

    assign accept = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign report.valid = out_valid_reg;
    assign report.data = out_reg;

    assign prev_idx = ord_reg[j_reg[IW-1:0] - IW'(1)];
    assign cur_idx  = ord_reg[k_reg[IW-1:0]];
    assign tk = cur_reg[key_reg];
    assign tp = cur_reg[prev_idx];
    always_comb
    begin
        if (tk != tp)
            key_first = desc_reg ? (tk > tp) : (tk < tp);
        else
            key_first = key_reg < prev_idx;
    end

    assign radd = cmd.data.region - 4'd1;
    assign rx = radd[IW-1:0];
    assign sum_c = {1'b0, cur_reg[rx]} + {17'd0, cmd.data.rain_amount};
    assign sum_p = {1'b0, past_reg[rx]} + {17'd0, cmd.data.past_rain_amount};

    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = cur_reg[cur_idx];
        dreq.divisor  = cnt_reg[cur_idx];
        if (state_reg == S_DIVA && drsp.done)
        begin
            dreq.dividend = past_reg[cur_idx];
        end
        if ((state_reg == S_DIVA || state_reg == S_DIVP) && !drsp.busy && !drsp.done
            && cnt_reg[cur_idx] != '0)
            dreq.start = 1'b1;
        if (state_reg == S_DIVA && drsp.done)
            dreq.start = 1'b1;
    end
    assign q = drsp.quotient;

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        key_next = key_reg;
        k_next = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.data.command == CMD_ASC || cmd.data.command == CMD_DESC))
                    state_next = S_INIT;
            end
            S_INIT:
            begin
                i_next = CW'(1);
                j_next = CW'(1);
                key_next = IW'(1);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (j_reg != '0 && key_first)
                    j_next = j_reg - CW'(1);
                else if (i_reg == CW'(REGIONS - 1))
                begin
                    k_next = '0;
                    state_next = S_DIVA;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    j_next = i_reg + CW'(1);
                    key_next = IW'(i_reg + CW'(1));
                end
            end
            S_DIVA:
            begin
                if (cnt_reg[cur_idx] == '0)
                    state_next = S_EMIT;
                else if (drsp.done)
                    state_next = S_DIVP;
            end
            S_DIVP:
            begin
                if (drsp.done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || report.ready)
                begin
                    if (k_reg == CW'(REGIONS - 1))
                        state_next = S_WAIT;
                    else
                    begin
                        k_next = k_reg + CW'(1);
                        state_next = S_DIVA;
                    end
                end
            end
            S_WAIT:
            begin
                if (!out_valid_reg || report.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < REGIONS; r++)
            begin
                cur_reg[r]  <= '0;
                past_reg[r] <= '0;
                cnt_reg[r]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EMIT && (!out_valid_reg || report.ready))
                out_valid_reg <= 1'b1;
            else if (report.ready)
                out_valid_reg <= 1'b0;
            if (accept && cmd.data.command == CMD_ADD && cmd.data.region != 4'd0
                && {1'b0, cmd.data.region} <= 5'(REGIONS))
            begin
                cur_reg[rx]  <= sum_c[TOTAL_W] ? '1 : sum_c[TOTAL_W-1:0];
                past_reg[rx] <= sum_p[TOTAL_W] ? '1 : sum_p[TOTAL_W-1:0];
                if (cnt_reg[rx] != '1)
                    cnt_reg[rx] <= cnt_reg[rx] + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        j_reg <= j_next;
        key_reg <= key_next;
        k_reg <= k_next;
        if (accept)
            desc_reg <= (cmd.data.command == CMD_DESC);
        if (state_reg == S_INIT)
            for (int r = 0; r < REGIONS; r++)
                ord_reg[r] <= IW'(r);
        if (state_reg == S_CMP)
        begin
            if (j_reg != '0 && key_first)
                ord_reg[j_reg[IW-1:0]] <= prev_idx;
            else
                ord_reg[j_reg[IW-1:0]] <= key_reg;
        end
        if (state_reg == S_DIVA && drsp.done)
            avg_reg <= q;
        if (state_reg == S_EMIT && (!out_valid_reg || report.ready))
        begin
            out_reg.region_id  <= 5'(cur_idx) + 5'd1;
            out_reg.total_rain <= cur_reg[cur_idx];
            out_reg.no_data    <= (cnt_reg[cur_idx] == '0);
            out_reg.last       <= (k_reg == CW'(REGIONS - 1));
            if (cnt_reg[cur_idx] == '0)
            begin
                out_reg.average_rain       <= '0;
                out_reg.average_difference <= '0;
            end
            else
            begin
                out_reg.average_rain       <= avg_reg;
                out_reg.average_difference <= (avg_reg >= q) ? avg_reg - q : q - avg_reg;
            end
        end
    end

    `RSSR_ASSERT_IMP(a_ready_idle, clk, rst_n, cmd.ready, state_reg == S_IDLE, "ready outside idle")
    `RSSR_ASSERT_IMP(a_nodata_avg, clk, rst_n, report.valid && report.data.no_data,
        report.data.average_rain == '0, "empty region with nonzero average")
    `RSSR_ASSERT_NEXT(a_emit_valid, clk, rst_n,
        state_reg == S_EMIT && (!out_valid_reg || report.ready),
        out_valid_reg, "report line lost")

endmodule
